[rtl/core/cht_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cht_pkg
// shared widths, parameter defaults and operation / status codes for the
// chained hash table
// ----------------------------------------------------------------------------
package cht_pkg;

    localparam int BUCKETS_DEF     = 64;
    localparam int CHAIN_DEPTH_DEF = 8;

    localparam int KEY_W    = 31;
    localparam int CFG_W    = 7;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 3;
    localparam int BKT_W    = 6;
    localparam int POS_W    = 3;
    localparam int DIV_CNT_W = $clog2(KEY_W);

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DEL_FAIL  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [KEY_W-1:0]  key;
    } req_t;

endpackage

`default_nettype wire

[rtl/core/chained_hash_table.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// chained_hash_table
// hash table with separate chaining, bucket = key modulo num_buckets, with 0 taken as 1
//   and values above BUCKETS (or 127, if smaller) clamped; each item runs the bit-serial
//   modulo, then walks or shifts chain entries through the one key ram read port, and
//   an insert or a delete that succeeds also writes the chain
// throughput: one item at a time; the next item is taken once the result is queued
// reset: synchronous active-low, then a sweep zeroes every chain length, during which
//   no item is accepted; num_buckets resets to 64
// ----------------------------------------------------------------------------
module chained_hash_table #(
    parameter int BUCKETS     = cht_pkg::BUCKETS_DEF,
    parameter int CHAIN_DEPTH = cht_pkg::CHAIN_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [6:0]  cfg_wr_data,   // num_buckets
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,       // func[1:0], key[32:2]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata        // status[2:0], bucket[8:3], position[11:9]
);

    localparam int BW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int KD   = BUCKETS * CHAIN_DEPTH;
    localparam int AW   = (KD > 1) ? $clog2(KD) : 1;
    localparam int LW   = $clog2(CHAIN_DEPTH + 1);
    localparam int CAP  = (BUCKETS < 127) ? BUCKETS : 127;
    localparam int KW   = cht_pkg::KEY_W;
    localparam int SW   = cht_pkg::STATUS_W;

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_HASH     = 4'd2;
    localparam logic [3:0] S_LEN_RD   = 4'd3;
    localparam logic [3:0] S_LEN_GET  = 4'd4;
    localparam logic [3:0] S_SH_RD    = 4'd5;
    localparam logic [3:0] S_SH_WR    = 4'd6;
    localparam logic [3:0] S_INS_HEAD = 4'd7;
    localparam logic [3:0] S_SC_RD    = 4'd8;
    localparam logic [3:0] S_SC_CMP   = 4'd9;
    localparam logic [3:0] S_DL_RD    = 4'd10;
    localparam logic [3:0] S_DL_WR    = 4'd11;
    localparam logic [3:0] S_DL_END   = 4'd12;
    localparam logic [3:0] S_DONE     = 4'd13;

    logic [3:0]                  state_reg, state_next;
    logic [cht_pkg::CFG_W-1:0]   nb_reg, nb_next;
    cht_pkg::req_t               req_reg, req_next;
    logic [BW-1:0]               idx_reg, idx_next;
    logic [BW-1:0]               clr_reg, clr_next;
    logic [cht_pkg::BKT_W-1:0]   bkt_reg, bkt_next;
    logic [AW-1:0]               base_reg, base_next;
    logic [LW-1:0]               len_reg, len_next;
    logic [LW-1:0]               ptr_reg, ptr_next;
    logic [SW-1:0]               st_reg, st_next;
    logic [LW-1:0]               pos_reg, pos_next;
    logic                        mv_reg, mv_next;
    logic [15:0]                 md_reg, md_next;

    logic [cht_pkg::CFG_W-1:0]   n_eff;
    logic                        div_start, div_done;
    logic [cht_pkg::CFG_W-1:0]   div_rem;
    logic [LW-1:0]               ptr_inc, ptr_dec;
    logic [LW+cht_pkg::POS_W-1:0] pos_ext;

    logic                        len_we;
    logic [BW-1:0]               len_waddr;
    logic [LW-1:0]               len_wdata, len_rdata;
    logic                        key_we;
    logic [AW-1:0]               key_waddr, key_raddr;
    logic [KW-1:0]               key_wdata, key_rdata;
    logic [LW-1:0]               rd_off;

    assign n_eff = (nb_reg == '0) ? cht_pkg::CFG_W'(1) :
                   (nb_reg > cht_pkg::CFG_W'(CAP)) ? cht_pkg::CFG_W'(CAP) : nb_reg;

    assign ptr_inc = ptr_reg + LW'(1);
    assign ptr_dec = ptr_reg - LW'(1);
    assign pos_ext = {{cht_pkg::POS_W{1'b0}}, pos_reg};

    assign div_start = s_tvalid && s_tready;

    cht_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (s_tdata[KW+1:2]),
        .divisor   (n_eff),
        .done      (div_done),
        .remainder (div_rem)
    );

    cht_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_len_ram (
        .aclk  (aclk),
        .we    (len_we),
        .waddr (len_waddr),
        .wdata (len_wdata),
        .raddr (idx_reg),
        .rdata (len_rdata)
    );

    cht_ram #(.WIDTH(KW), .DEPTH(KD)) u_key_ram (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    always_comb begin
        unique case (state_reg)
            S_SH_RD: rd_off = ptr_dec;
            S_DL_RD: rd_off = ptr_inc;
            default: rd_off = ptr_reg;
        endcase
    end

    assign key_raddr = base_reg + AW'(rd_off);

    always_comb begin
        state_next = state_reg;
        nb_next    = cfg_wr_en ? cfg_wr_data : nb_reg;
        req_next   = req_reg;
        idx_next   = idx_reg;
        clr_next   = clr_reg;
        bkt_next   = bkt_reg;
        base_next  = base_reg;
        len_next   = len_reg;
        ptr_next   = ptr_reg;
        st_next    = st_reg;
        pos_next   = pos_reg;
        mv_next    = mv_reg && !m_tready;
        md_next    = md_reg;
        len_we     = 1'b0;
        len_waddr  = idx_reg;
        len_wdata  = '0;
        key_we     = 1'b0;
        key_waddr  = base_reg + AW'(ptr_reg);
        key_wdata  = key_rdata;
        s_tready   = 1'b0;

        unique case (state_reg)
            S_CLEAR: begin
                len_we    = 1'b1;
                len_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == BW'(BUCKETS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    req_next.func = s_tdata[1:0];
                    req_next.key  = s_tdata[KW+1:2];
                    state_next    = S_HASH;
                end
            end
            S_HASH: begin
                if (div_done) begin
                    idx_next   = BW'(div_rem);
                    bkt_next   = div_rem[cht_pkg::BKT_W-1:0];
                    state_next = S_LEN_RD;
                end
            end
            S_LEN_RD: begin
                base_next  = AW'(idx_reg) * AW'(CHAIN_DEPTH);
                state_next = S_LEN_GET;
            end
            S_LEN_GET: begin
                len_next = len_rdata;
                pos_next = '0;
                if (req_reg.func == cht_pkg::FUNC_INSERT) begin
                    ptr_next = len_rdata;
                    if (len_rdata >= LW'(CHAIN_DEPTH)) begin
                        st_next    = cht_pkg::ST_FULL;
                        state_next = S_DONE;
                    end else if (len_rdata == '0) begin
                        state_next = S_INS_HEAD;
                    end else begin
                        state_next = S_SH_RD;
                    end
                end else begin
                    ptr_next = '0;
                    if (len_rdata == '0) begin
                        st_next    = (req_reg.func == cht_pkg::FUNC_DELETE) ?
                                     cht_pkg::ST_DEL_FAIL : cht_pkg::ST_NOT_FOUND;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_SC_RD;
                    end
                end
            end
            S_SH_RD: begin
                state_next = S_SH_WR;
            end
            S_SH_WR: begin
                key_we   = 1'b1;
                ptr_next = ptr_dec;
                state_next = (ptr_dec == '0) ? S_INS_HEAD : S_SH_RD;
            end
            S_INS_HEAD: begin
                key_we     = 1'b1;
                key_waddr  = base_reg;
                key_wdata  = req_reg.key;
                len_we     = 1'b1;
                len_wdata  = len_reg + LW'(1);
                st_next    = cht_pkg::ST_INSERTED;
                state_next = S_DONE;
            end
            S_SC_RD: begin
                state_next = S_SC_CMP;
            end
            S_SC_CMP: begin
                if (key_rdata == req_reg.key) begin
                    pos_next = ptr_reg;
                    if (req_reg.func == cht_pkg::FUNC_DELETE) begin
                        state_next = (ptr_inc < len_reg) ? S_DL_RD : S_DL_END;
                    end else begin
                        st_next    = cht_pkg::ST_FOUND;
                        state_next = S_DONE;
                    end
                end else if (ptr_inc >= len_reg) begin
                    st_next    = (req_reg.func == cht_pkg::FUNC_DELETE) ?
                                 cht_pkg::ST_DEL_FAIL : cht_pkg::ST_NOT_FOUND;
                    state_next = S_DONE;
                end else begin
                    ptr_next   = ptr_inc;
                    state_next = S_SC_RD;
                end
            end
            S_DL_RD: begin
                state_next = S_DL_WR;
            end
            S_DL_WR: begin
                key_we   = 1'b1;
                ptr_next = ptr_inc;
                state_next = ((ptr_inc + LW'(1)) < len_reg) ? S_DL_RD : S_DL_END;
            end
            S_DL_END: begin
                len_we     = 1'b1;
                len_wdata  = len_reg - LW'(1);
                st_next    = cht_pkg::ST_DELETED;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!mv_reg || m_tready) begin
                    mv_next    = 1'b1;
                    md_next    = {4'b0, pos_ext[cht_pkg::POS_W-1:0], bkt_reg, st_reg};
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            nb_reg    <= cht_pkg::CFG_RESET;
            clr_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            nb_reg    <= nb_next;
            clr_reg   <= clr_next;
            mv_reg    <= mv_next;
        end
        req_reg  <= req_next;
        idx_reg  <= idx_next;
        bkt_reg  <= bkt_next;
        base_reg <= base_next;
        len_reg  <= len_next;
        ptr_reg  <= ptr_next;
        st_reg   <= st_next;
        pos_reg  <= pos_next;
        md_reg   <= md_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;

endmodule

`default_nettype wire

[rtl/core/cht_divider.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cht_divider
// restoring remainder unit, one key bit per cycle: key modulo bucket count
// ----------------------------------------------------------------------------
module cht_divider (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [cht_pkg::KEY_W-1:0] dividend,
    input  wire logic [cht_pkg::CFG_W-1:0] divisor,
    output logic                           done,
    output logic [cht_pkg::CFG_W-1:0]      remainder
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [cht_pkg::DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [cht_pkg::KEY_W-1:0]         key_reg, key_next;
    logic [cht_pkg::CFG_W-1:0]         div_reg, div_next;
    logic [cht_pkg::CFG_W-1:0]         rem_reg, rem_next;
    logic [cht_pkg::CFG_W:0]           trial;

    assign trial = {rem_reg, key_reg[cht_pkg::KEY_W-1]};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        key_next  = key_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            key_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            key_next = {key_reg[cht_pkg::KEY_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg}) begin
                rem_next = cht_pkg::CFG_W'(trial - {1'b0, div_reg});
            end else begin
                rem_next = cht_pkg::CFG_W'(trial);
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == cht_pkg::DIV_CNT_W'(cht_pkg::KEY_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        key_reg <= key_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

[rtl/core/cht_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cht_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module cht_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0]      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for chained_hash_table: a local model of the chains
// predicts status, bucket and position for every item sent, across several
// bucket counts and with random gaps and back-pressure on both sides
// ----------------------------------------------------------------------------
module testbench;
    import cht_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_SPARE  = 2'd3;
    localparam int  N_BUCKETS    = BUCKETS_DEF;
    localparam int  N_DEPTH      = CHAIN_DEPTH_DEF;
    localparam int  CYCLE_LIMIT  = 1000000;
    localparam int  ITEMS_PER_PHASE = 165;
    localparam logic [KEY_W-1:0] KEY_MAX = 31'h7fffffff;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BKT_W-1:0]    bucket;
        logic [POS_W-1:0]    position;
    } result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [6:0]  cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    logic [KEY_W-1:0] chain_key_mem [N_BUCKETS][N_DEPTH];
    int               chain_len [N_BUCKETS];
    logic [CFG_W-1:0] bucket_count;
    result_t          pending_results [$];
    int               error_count = 0;
    int               cycle_count = 0;
    int               rx_stall_left = 0;
    int               rx_stall_draw;
    bit               quiet_mode = 1'b0;

    chained_hash_table dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // expected result of one request, updating the chains as the block does
    function automatic result_t hash_table_step(input logic [FUNC_W-1:0] op,
                                                input logic [KEY_W-1:0] key);
        result_t r;
        int nb;
        int b;
        int len;
        int hit;
        int i;
        nb = bucket_count;
        if (nb == 0) nb = 1;
        if (nb > N_BUCKETS) nb = N_BUCKETS;
        b = int'(key) % nb;
        len = chain_len[b];
        hit = N_DEPTH;
        r.bucket = b[BKT_W-1:0];
        r.position = '0;
        for (i = 0; i < len; i++) begin
            if (chain_key_mem[b][i] == key && hit == N_DEPTH) hit = i;
        end
        if (op == FUNC_INSERT) begin
            if (len >= N_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                for (i = len; i > 0; i--) chain_key_mem[b][i] = chain_key_mem[b][i-1];
                chain_key_mem[b][0] = key;
                chain_len[b] = len + 1;
                r.status = ST_INSERTED;
            end
        end else if (op == FUNC_DELETE) begin
            if (hit == N_DEPTH) begin
                r.status = ST_DEL_FAIL;
            end else begin
                for (i = hit; i + 1 < len; i++) chain_key_mem[b][i] = chain_key_mem[b][i+1];
                chain_len[b] = len - 1;
                r.status = ST_DELETED;
                r.position = hit[POS_W-1:0];
            end
        end else begin
            if (hit == N_DEPTH) begin
                r.status = ST_NOT_FOUND;
            end else begin
                r.status = ST_FOUND;
                r.position = hit[POS_W-1:0];
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_result(input logic [15:0] data);
        result_t got;
        result_t want;
        got.status = data[2:0];
        got.bucket = data[8:3];
        got.position = data[11:9];
        if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h", data));
        end else begin
            want = pending_results.pop_front();
            if (got.status != want.status)
                report_mismatch($sformatf("status %0d, expected %0d",
                                          got.status, want.status));
            if (got.bucket != want.bucket)
                report_mismatch($sformatf("bucket %0d, expected %0d",
                                          got.bucket, want.bucket));
            if (got.position != want.position)
                report_mismatch($sformatf("position %0d, expected %0d",
                                          got.position, want.position));
        end
    endtask

    // result side: random stall after each item
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_stall_left <= 0;
        end else if (m_tvalid && m_tready) begin
            check_result(m_tdata);
            rx_stall_draw = quiet_mode ? 0 : $urandom_range(0, 7);
            rx_stall_left <= rx_stall_draw;
            m_tready <= (rx_stall_draw == 0);
        end else if (rx_stall_left != 0) begin
            rx_stall_left <= rx_stall_left - 1;
            m_tready <= (rx_stall_left == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_item(input logic [FUNC_W-1:0] op, input logic [KEY_W-1:0] key);
        int gap;
        gap = quiet_mode ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, key, op};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(hash_table_step(op, key));
    endtask

    task automatic wait_idle(input int settle);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_bucket_count(input logic [CFG_W-1:0] value);
        wait_idle(4);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        bucket_count = value;
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // reset count of 64: empty chains, order in a chain, full chain
    task automatic test_directed();
        int k;
        send_item(FUNC_SEARCH, 31'd0);
        send_item(FUNC_DELETE, 31'd5);
        send_item(FUNC_INSERT, 31'd0);
        send_item(FUNC_INSERT, 31'd64);
        send_item(FUNC_INSERT, 31'd128);
        send_item(FUNC_SEARCH, 31'd0);
        send_item(FUNC_SEARCH, 31'd128);
        send_item(FUNC_SPARE, 31'd64);
        send_item(FUNC_DELETE, 31'd64);
        send_item(FUNC_SEARCH, 31'd0);
        send_item(FUNC_INSERT, KEY_MAX);
        send_item(FUNC_SEARCH, KEY_MAX);
        send_item(FUNC_INSERT, 31'h2aaaaaaa);
        send_item(FUNC_INSERT, 31'h55555555);
        for (k = 0; k < N_DEPTH; k++) send_item(FUNC_INSERT, 31'(7 + 64 * k));
        send_item(FUNC_INSERT, 31'd7);
        send_item(FUNC_DELETE, 31'd7);
        send_item(FUNC_DELETE, 31'(7 + 64 * 7));
    endtask

    // count of zero, over the range, and changed with keys stored
    task automatic test_bucket_count();
        int k;
        write_bucket_count(7'd0);
        send_item(FUNC_SEARCH, 31'd71);
        for (k = 0; k < 7; k++) send_item(FUNC_INSERT, 31'($urandom_range(1, 1000)));
        send_item(FUNC_SEARCH, 31'd128);
        write_bucket_count(7'd127);
        send_item(FUNC_SEARCH, 31'd71);
        send_item(FUNC_SEARCH, KEY_MAX);
        write_bucket_count(7'd65);
        send_item(FUNC_DELETE, 31'd135);
        send_item(FUNC_INSERT, KEY_MAX);
        write_bucket_count(7'd1);
        send_item(FUNC_INSERT, 31'd9);
        send_item(FUNC_DELETE, 31'd0);
        write_bucket_count(7'd37);
        send_item(FUNC_INSERT, KEY_MAX);
        send_item(FUNC_SPARE, KEY_MAX);
    endtask

    // phases of traffic over a small key pool so chains fill, hit and drain
    task automatic test_random_traffic();
        logic [CFG_W-1:0] phase_counts [10];
        logic [KEY_W-1:0] key_pool [12];
        logic [FUNC_W-1:0] op;
        logic [KEY_W-1:0] key;
        int phase;
        int n;
        int pick;
        phase_counts = '{7'd64, 7'd1, 7'd127, 7'd0, 7'd3, 7'd100, 7'd64, 7'd2, 7'd17, 7'd5};
        phase_counts[4] = 7'($urandom_range(2, 63));
        phase_counts[8] = 7'($urandom_range(2, 63));
        for (phase = 0; phase < 10; phase++) begin
            write_bucket_count(phase_counts[phase]);
            quiet_mode = (phase % 3 == 2);
            for (n = 0; n < 12; n++) begin
                if (n < 6) key_pool[n] = 31'($urandom_range(0, 255));
                else key_pool[n] = 31'($urandom);
            end
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick = $urandom_range(0, 99);
                key = key_pool[$urandom_range(0, 11)];
                if (pick < 5) begin
                    op = 2'($urandom_range(0, 3));
                    key = 31'($urandom);
                end else if (pick < 47) begin
                    op = FUNC_INSERT;
                end else if (pick < 75) begin
                    op = FUNC_DELETE;
                end else if (pick < 95) begin
                    op = FUNC_SEARCH;
                end else begin
                    op = FUNC_SPARE;
                end
                send_item(op, key);
            end
        end
        quiet_mode = 1'b0;
    endtask

    initial begin
        for (int b = 0; b < N_BUCKETS; b++) begin
            chain_len[b] = 0;
            for (int i = 0; i < N_DEPTH; i++) chain_key_mem[b][i] = '0;
        end
        bucket_count = CFG_RESET;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_bucket_count();
        test_random_traffic();
        wait_idle(60);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[chained_hash_table.f]
rtl/core/cht_pkg.sv
rtl/core/cht_divider.sv
rtl/core/cht_ram.sv
rtl/core/chained_hash_table.sv
tb/testbench.sv
